### hw/rtl/biou_pkg.sv
// ---------------------------------------------------------------------------
// biou_pkg: shared types for the box IoU distance engine
// Box record and the tag that travels with each result through the pipeline.
// ---------------------------------------------------------------------------
package biou_pkg;

   // One box in signed fixed point with two fraction bits.
   typedef struct packed {
      logic signed [15:0] l;
      logic signed [15:0] t;
      logic signed [15:0] r;
      logic signed [15:0] b;
   } box_type;

   // Sideband carried beside the divider data.
   typedef struct packed {
      logic [3:0] track_index;
      logic [7:0] det_index;
      logic       last;
      logic       full;   // distance is the full scale value
      logic       zero;   // distance is zero
   } tag_type;

   // One pixel in raw coordinate units.
   localparam logic signed [17:0] ONE_PIXEL = 18'sd4;

endpackage

### hw/rtl/biou_track_cell.sv
// ---------------------------------------------------------------------------
// biou_track_cell: one slot of the track box chain
// Holds one track box; loads a new box or takes its neighbor's box on a shift.
// ---------------------------------------------------------------------------
module biou_track_cell
   import biou_pkg::*;
(
   input  logic    clock,
   input  logic    load,
   input  box_type load_box,
   input  logic    shift,
   input  box_type nbr_box,
   output box_type box
);

   box_type box_ff;
   box_type box_in;

   always_comb begin
      box_in = box_ff;
      if (load) begin
         box_in = load_box;
      end else if (shift) begin
         box_in = nbr_box;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box = box_ff;

endmodule

### hw/rtl/biou_div_cell.sv
// ---------------------------------------------------------------------------
// biou_div_cell: one restoring division step
// Produces one quotient bit per stage and registers the partial remainder.
// ---------------------------------------------------------------------------
module biou_div_cell
   import biou_pkg::*;
#(
   parameter int F  = 16,
   parameter int RW = 38
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  tag_type       in_tag,
   input  logic [RW-1:0] in_rem,
   input  logic [RW-1:0] in_div,
   input  logic [F-1:0]  in_quo,
   output logic          out_valid,
   output tag_type       out_tag,
   output logic [RW-1:0] out_rem,
   output logic [RW-1:0] out_div,
   output logic [F-1:0]  out_quo
);

   logic          valid_ff;
   tag_type       tag_ff;
   logic [RW-1:0] rem_ff, div_ff;
   logic [F-1:0]  quo_ff;
   logic [RW-1:0] sh;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [F-1:0]  quo_in;

   always_comb begin
      sh     = {in_rem[RW-2:0], 1'b0};
      ge     = (sh >= in_div);
      rem_in = ge ? (sh - in_div) : sh;
      quo_in = {in_quo[F-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff <= in_tag;
         rem_ff <= rem_in;
         div_ff <= in_div;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;

endmodule

### hw/rtl/box_iou_distance_engine_core.sv
// ---------------------------------------------------------------------------
// box_iou_distance_engine_core: IoU distance between track and detection boxes
// Stores track boxes in a rotating chain of cells and scores each detection
// box against every stored track through a pipelined restoring divider.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake          | carries
//   req_    | in        | req_valid/req_stall| kind, restart, four box edges
//   rsp_    | out       | rsp_valid/rsp_stall| track, detection, distance, last
//
// A track request is taken whenever the request side is free. A detection
// request stalls the request side while the track chain makes one full turn,
// and no new detection is taken until the turn ends; one result per stored
// track passes the overlap, area and union stages, the divider and the output
// register. Reset clears counters, the busy flag and valid flags only; track
// boxes are undefined until written. A stall on the result side freezes the
// whole pipeline and the chain together, so no result is lost or repeated.
// ---------------------------------------------------------------------------
module box_iou_distance_engine_core
   import biou_pkg::*;
#(
   parameter int MAX_TRACKS     = 16,
   parameter int DIST_FRAC_BITS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_restart,
   input  logic signed [15:0] req_box_left,
   input  logic signed [15:0] req_box_top,
   input  logic signed [15:0] req_box_right,
   input  logic signed [15:0] req_box_bottom,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_track_index,
   output logic [7:0]         rsp_detection_index,
   output logic [16:0]        rsp_distance,
   output logic               rsp_last
);

   localparam int CW = $clog2(MAX_TRACKS + 1);
   localparam int F  = DIST_FRAC_BITS;
   localparam int RW = 38;

   // Control state of the request side.
   logic          busy_ff, busy_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    det_cnt_ff, det_cnt_in;
   logic [7:0]    cur_det_ff, cur_det_in;
   box_type       det_box_ff, det_box_in;

   logic          advance;
   logic          accept;
   logic          store_en;
   logic [CW-1:0] eff_count;
   box_type       req_box;
   box_type       cell_box [MAX_TRACKS];

   // The whole pipeline moves unless a finished result is held back.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   assign req_box.l = req_box_left;
   assign req_box.t = req_box_top;
   assign req_box.r = req_box_right;
   assign req_box.b = req_box_bottom;

   // A restart empties the store before the new box lands in slot zero.
   assign eff_count = req_restart ? '0 : count_ff;
   assign store_en  = accept && !req_kind && (eff_count < CW'(MAX_TRACKS));

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      det_cnt_in = det_cnt_ff;
      cur_det_in = cur_det_ff;
      det_box_in = det_box_ff;
      if (accept && !req_kind) begin
         if (req_restart) begin
            det_cnt_in = '0;
         end
         count_in = store_en ? (eff_count + 1'b1) : eff_count;
      end else if (accept && req_kind) begin
         busy_in    = 1'b1;
         step_in    = '0;
         det_box_in = req_box;
         cur_det_in = det_cnt_ff;
         if (det_cnt_ff != 8'hFF) begin
            det_cnt_in = det_cnt_ff + 8'd1;
         end
      end else if (busy_ff && advance) begin
         // One turn of the chain visits every slot once.
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(MAX_TRACKS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ff    <= '0;
         count_ff   <= '0;
         det_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         step_ff    <= step_in;
         count_ff   <= count_in;
         det_cnt_ff <= det_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_det_ff <= cur_det_in;
      det_box_ff <= det_box_in;
   end

   // Track chain: slot zero is the head that feeds the arithmetic, and every
   // slot takes its upper neighbor's box on a shift, the head wrapping around.
   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
      biou_track_cell u_cell (
         .clock    (clock),
         .load     (store_en && (eff_count == CW'(i))),
         .load_box (req_box),
         .shift    (busy_ff && advance),
         .nbr_box  (cell_box[(i + 1) % MAX_TRACKS]),
         .box      (cell_box[i])
      );
   end

   // Stage 1: overlap and box extents.
   logic               s1_valid_ff;
   tag_type            s1_tag_ff, s1_tag_in;
   logic signed [17:0] s1_iw_ff, s1_ih_ff, s1_wa_ff, s1_ha_ff, s1_wd_ff, s1_hd_ff;
   logic signed [17:0] hl, ht, hr, hb, dl, dt, dr, db;
   logic signed [17:0] iw, ih;

   always_comb begin
      hl = 18'($signed(cell_box[0].l));
      ht = 18'($signed(cell_box[0].t));
      hr = 18'($signed(cell_box[0].r));
      hb = 18'($signed(cell_box[0].b));
      dl = 18'($signed(det_box_ff.l));
      dt = 18'($signed(det_box_ff.t));
      dr = 18'($signed(det_box_ff.r));
      db = 18'($signed(det_box_ff.b));
      iw = ((hr < dr) ? hr : dr) - ((hl > dl) ? hl : dl) + ONE_PIXEL;
      ih = ((hb < db) ? hb : db) - ((ht > dt) ? ht : dt) + ONE_PIXEL;
      s1_tag_in.track_index = 4'(step_ff);
      s1_tag_in.det_index   = cur_det_ff;
      s1_tag_in.last        = ((step_ff + 1'b1) == count_ff);
      s1_tag_in.full        = (iw <= 18'sd0) || (ih <= 18'sd0);
      s1_tag_in.zero        = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= busy_ff && (step_ff < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff <= s1_tag_in;
         s1_iw_ff  <= iw;
         s1_ih_ff  <= ih;
         s1_wa_ff  <= hr - hl + ONE_PIXEL;
         s1_ha_ff  <= hb - ht + ONE_PIXEL;
         s1_wd_ff  <= dr - dl + ONE_PIXEL;
         s1_hd_ff  <= db - dt + ONE_PIXEL;
      end
   end

   // Stage 2: overlap area and both box areas, which may be negative.
   logic               s2_valid_ff;
   tag_type            s2_tag_ff;
   logic signed [35:0] s2_inter_ff, s2_area_a_ff, s2_area_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_tag_ff    <= s1_tag_ff;
         s2_inter_ff  <= s1_iw_ff * s1_ih_ff;
         s2_area_a_ff <= s1_wa_ff * s1_ha_ff;
         s2_area_d_ff <= s1_wd_ff * s1_hd_ff;
      end
   end

   // Stage 3: union and the special outcomes. When the overlap reaches the
   // union the quotient would be at least full scale; distance 0 unless full.
   logic               s3_valid_ff;
   tag_type            s3_tag_ff, s3_tag_in;
   logic [RW-1:0]      s3_rem_ff, s3_div_ff;
   logic signed [37:0] uni, inter_x;

   always_comb begin
      inter_x        = 38'(s2_inter_ff);
      uni            = 38'(s2_area_a_ff) + 38'(s2_area_d_ff) - inter_x;
      s3_tag_in      = s2_tag_ff;
      s3_tag_in.full = s2_tag_ff.full || (uni <= 38'sd0);
      s3_tag_in.zero = (inter_x >= uni);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_tag_ff <= s3_tag_in;
         s3_rem_ff <= RW'(inter_x);
         s3_div_ff <= RW'(uni);
      end
   end

   // Divider: one quotient bit per stage, F stages.
   logic          dv_valid [F+1];
   tag_type       dv_tag   [F+1];
   logic [RW-1:0] dv_rem   [F+1];
   logic [RW-1:0] dv_div   [F+1];
   logic [F-1:0]  dv_quo   [F+1];

   assign dv_valid[0] = s3_valid_ff;
   assign dv_tag[0]   = s3_tag_ff;
   assign dv_rem[0]   = s3_rem_ff;
   assign dv_div[0]   = s3_div_ff;
   assign dv_quo[0]   = '0;

   for (genvar k = 0; k < F; k++) begin : g_div
      biou_div_cell #(.F(F), .RW(RW)) u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[k]),
         .in_tag    (dv_tag[k]),
         .in_rem    (dv_rem[k]),
         .in_div    (dv_div[k]),
         .in_quo    (dv_quo[k]),
         .out_valid (dv_valid[k+1]),
         .out_tag   (dv_tag[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_div   (dv_div[k+1]),
         .out_quo   (dv_quo[k+1])
      );
   end

   // Output register.
   logic          rsp_valid_ff;
   logic [3:0]    rsp_track_ff;
   logic [7:0]    rsp_det_ff;
   logic [16:0]   rsp_dist_ff;
   logic          rsp_last_ff;
   logic [F:0]    dist_val;
   logic [F:0]    full_val;

   always_comb begin
      full_val = {1'b1, {F{1'b0}}};
      if (dv_tag[F].full) begin
         dist_val = full_val;
      end else if (dv_tag[F].zero) begin
         dist_val = '0;
      end else begin
         dist_val = full_val - {1'b0, dv_quo[F]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[F];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_track_ff <= dv_tag[F].track_index;
         rsp_det_ff   <= dv_tag[F].det_index;
         rsp_dist_ff  <= 17'(dist_val);
         rsp_last_ff  <= dv_tag[F].last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_track_index     = rsp_track_ff;
   assign rsp_detection_index = rsp_det_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

### hw/rtl/biou_checker.sv
// ---------------------------------------------------------------------------
// biou_checker: port checks for the box IoU distance engine
// Watches the request and result ports and flags illegal behavior over time.
// ---------------------------------------------------------------------------
module biou_checker #(
   parameter int DIST_FRAC_BITS = 16
)(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [16:0]        rsp_distance
);

   // A held result stays offered with the same distance.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("result dropped or changed while stalled");

   // The distance never exceeds full scale when DIST_FRAC_BITS is at most 16.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DIST_FRAC_BITS > 16) ||
                    (rsp_distance <= 17'(1 << DIST_FRAC_BITS)))
      else $error("distance above full scale");

   // A detection request blocks further requests while the chain turns.
   a_det_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind |=> req_stall)
      else $error("detection request did not occupy the engine");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind box_iou_distance_engine_core biou_checker #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_chk (.*);
